// ----- sv/pprd_pkg.sv -----
// shared types and constants for the pulse peak rate detector
package pprd_pkg;

    localparam int SAMPLE_W   = 18;
    localparam int RATE_W     = 21;
    localparam int POS_W      = 32;
    localparam int HYST_W     = 18;
    localparam int SPM_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int STEP_W     = $clog2(RATE_W);

    localparam logic [HYST_W-1:0] HYST_RESET = HYST_W'(300);
    localparam logic [SPM_W-1:0]  SPM_RESET  = SPM_W'(6000);

    // quick rate: fifth peak, three intervals back to the second peak
    localparam int QUICK_COUNT = 5;
    localparam int QUICK_SPANS = 3;
    localparam int QUICK_ENTRY = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HYSTERESIS = 2'd0,
        REG_SPM        = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_MAX  = 2'd1,
        EV_MIN  = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RING_OLD,
        ST_RING_ONE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] dividend;
        logic [POS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- sv/pprd_ring_mem.sv -----
// peak position ring: synchronous memory with per-entry valid bits
module pprd_ring_mem #(
    parameter int DEPTH  = 10,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [pprd_pkg::POS_W-1:0]   rd_data,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [pprd_pkg::POS_W-1:0]   wr_data
);

    logic [pprd_pkg::POS_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic [pprd_pkg::POS_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // read-first; an entry never written reads as zero
    always_ff @(posedge aclk) begin
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/pprd_divider.sv -----
// restoring divider, one quotient bit per cycle
module pprd_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  pprd_pkg::div_req_t req,
    output pprd_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [pprd_pkg::STEP_W-1:0]   step_reg;
    logic [pprd_pkg::POS_W-1:0]    rem_reg;
    logic [pprd_pkg::POS_W-1:0]    den_reg;
    logic [pprd_pkg::RATE_W-1:0]   quo_reg;

    logic [pprd_pkg::POS_W:0]      trial;
    logic [pprd_pkg::POS_W:0]      diff;
    logic                          fits;

    always_comb begin
        trial = {rem_reg, quo_reg[pprd_pkg::RATE_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= pprd_pkg::STEP_W'(pprd_pkg::RATE_W - 1);
            end else if (busy_reg) begin
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - pprd_pkg::STEP_W'(1);
                end
            end
        end
    end

    // dividend bits shift out the top as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            den_reg <= req.divisor;
            quo_reg <= req.dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[pprd_pkg::POS_W-1:0] : trial[pprd_pkg::POS_W-1:0];
            quo_reg <= {quo_reg[pprd_pkg::RATE_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- sv/pulse_peak_rate_detector_core.sv -----
// top level of the pulse peak rate detector
//
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_sample
// m_        out        m_valid / m_ready  m_rate, m_event_res, m_extreme_value, m_falling_phase
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// one item at a time: a sample that confirms no maximum goes from IDLE straight to OUT;
// a confirmed maximum steps through RING_OLD and RING_ONE for the ring read-modify-write,
// then through DIV for the bit-serial divider when it needs a rate, before OUT
// synchronous active-low reset; ring entries start as zero through valid bits
// a result waits in the output register while the next sample is taken;
// with the output stalled, a finished item holds until the transfer
module pulse_peak_rate_detector_core #(
    parameter int RING_DEPTH = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [pprd_pkg::SAMPLE_W-1:0]      s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pprd_pkg::RATE_W-1:0]        m_rate,
    output logic [1:0]                         m_event_res,
    output logic [pprd_pkg::SAMPLE_W-1:0]      m_extreme_value,
    output logic                               m_falling_phase,
    input  logic                               cfg_wr_en,
    input  logic [pprd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pprd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int ADDR_W    = $clog2(RING_DEPTH);
    localparam int COUNT_MAX = RING_DEPTH + 2;
    localparam int CNT_W     = $clog2(RING_DEPTH + 3);

    // configuration registers
    logic [pprd_pkg::HYST_W-1:0]   hyst_reg;
    logic [pprd_pkg::SPM_W-1:0]    spm_reg;

    // tracking state
    pprd_pkg::state_t              state_reg, state_next;
    logic                          rising_reg;
    logic [pprd_pkg::SAMPLE_W-1:0] max_reg;
    logic [pprd_pkg::SAMPLE_W-1:0] min_reg;
    logic [pprd_pkg::POS_W-1:0]    index_reg;
    logic [pprd_pkg::POS_W-1:0]    max_pos_reg;
    logic [ADDR_W-1:0]             ptr_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [pprd_pkg::POS_W-1:0]    old_pos_reg;

    // result being built, then the output register
    logic [pprd_pkg::RATE_W-1:0]   res_rate_reg;
    pprd_pkg::event_t              res_event_reg;
    logic [pprd_pkg::SAMPLE_W-1:0] res_extreme_reg;
    logic                          m_valid_reg;
    logic [pprd_pkg::RATE_W-1:0]   m_rate_reg;
    pprd_pkg::event_t              m_event_reg;
    logic [pprd_pkg::SAMPLE_W-1:0] m_extreme_reg;
    logic                          m_falling_reg;

    // ring and divider hookup
    logic [ADDR_W-1:0]             ring_rd_addr;
    logic [pprd_pkg::POS_W-1:0]    ring_rd_data;
    logic                          ring_wr_en;
    pprd_pkg::div_req_t            div_req;
    pprd_pkg::div_rsp_t            div_rsp;

    // per-sample decisions
    logic                          accept;
    logic                          load_out;
    logic [pprd_pkg::POS_W-1:0]    index_inc;
    logic                          new_max;
    logic                          peak_hit;
    logic                          new_min;
    logic                          valley_hit;
    logic                          quick_rate;
    logic                          full_rate;
    logic [pprd_pkg::POS_W-1:0]    span;
    logic [pprd_pkg::RATE_W-1:0]   spm_ext;
    logic [pprd_pkg::RATE_W-1:0]   numerator;
    logic                          do_div;
    logic [ADDR_W-1:0]             ptr_inc;

    // no transfer is taken while reset is held
    assign s_ready  = aresetn && (state_reg == pprd_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == pprd_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    // extreme tracking with hysteresis
    always_comb begin
        index_inc  = index_reg + pprd_pkg::POS_W'(1);
        new_max    = s_sample > max_reg;
        peak_hit   = !new_max && ((max_reg - s_sample) > hyst_reg);
        new_min    = s_sample < min_reg;
        valley_hit = !new_min && ((s_sample - min_reg) > hyst_reg);
        ptr_inc    = (ptr_reg == ADDR_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + ADDR_W'(1);
    end

    // rate selection once the ring entries are back
    always_comb begin
        quick_rate = (count_reg == CNT_W'(pprd_pkg::QUICK_COUNT));
        full_rate  = (count_reg == CNT_W'(COUNT_MAX));
        span       = max_pos_reg - (quick_rate ? ring_rd_data : old_pos_reg);
        spm_ext    = pprd_pkg::RATE_W'(spm_reg);
        numerator  = quick_rate ? spm_ext * pprd_pkg::RATE_W'(pprd_pkg::QUICK_SPANS)
                                : spm_ext * pprd_pkg::RATE_W'(RING_DEPTH);
        do_div     = (state_reg == pprd_pkg::ST_RING_ONE) && (quick_rate || full_rate)
                     && (span != '0);
    end

    assign div_req.start    = do_div;
    assign div_req.dividend = numerator;
    assign div_req.divisor  = span;

    // old entry at the pointer first, then entry one for the quick rate
    assign ring_rd_addr = (state_reg == pprd_pkg::ST_IDLE)
                          ? ptr_reg : ADDR_W'(pprd_pkg::QUICK_ENTRY);
    assign ring_wr_en   = (state_reg == pprd_pkg::ST_RING_OLD);

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pprd_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (rising_reg && peak_hit) ? pprd_pkg::ST_RING_OLD
                                                          : pprd_pkg::ST_OUT;
                end
            end
            pprd_pkg::ST_RING_OLD: state_next = pprd_pkg::ST_RING_ONE;
            pprd_pkg::ST_RING_ONE: state_next = do_div ? pprd_pkg::ST_DIV : pprd_pkg::ST_OUT;
            pprd_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = pprd_pkg::ST_OUT;
                end
            end
            pprd_pkg::ST_OUT: begin
                if (load_out) begin
                    state_next = pprd_pkg::ST_IDLE;
                end
            end
            default: state_next = pprd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pprd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hyst_reg <= pprd_pkg::HYST_RESET;
            spm_reg  <= pprd_pkg::SPM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pprd_pkg::REG_HYSTERESIS: hyst_reg <= cfg_wdata[pprd_pkg::HYST_W-1:0];
                pprd_pkg::REG_SPM:        spm_reg  <= cfg_wdata[pprd_pkg::SPM_W-1:0];
                default: ;
            endcase
        end
    end

    // tracking state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rising_reg  <= 1'b1;
            max_reg     <= '0;
            min_reg     <= '1;
            index_reg   <= '0;
            max_pos_reg <= '0;
            ptr_reg     <= '0;
            count_reg   <= '0;
        end else begin
            if (accept) begin
                index_reg <= index_inc;
                if (rising_reg) begin
                    if (new_max) begin
                        max_reg     <= s_sample;
                        max_pos_reg <= index_inc;
                    end else if (peak_hit) begin
                        rising_reg <= 1'b0;
                        min_reg    <= max_reg;
                        if (count_reg != CNT_W'(COUNT_MAX)) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                end else begin
                    if (new_min) begin
                        min_reg <= s_sample;
                    end else if (valley_hit) begin
                        rising_reg <= 1'b1;
                        max_reg    <= min_reg;
                    end
                end
            end
            if (ring_wr_en) begin
                ptr_reg <= ptr_inc;
            end
        end
    end

    // result assembly
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_rate_reg    <= '0;
            res_event_reg   <= pprd_pkg::EV_NONE;
            res_extreme_reg <= '0;
            if (rising_reg && !new_max && peak_hit) begin
                res_event_reg   <= pprd_pkg::EV_MAX;
                res_extreme_reg <= max_reg;
            end else if (!rising_reg && !new_min && valley_hit) begin
                res_event_reg   <= pprd_pkg::EV_MIN;
                res_extreme_reg <= min_reg;
            end
        end
        if (state_reg == pprd_pkg::ST_RING_OLD) begin
            old_pos_reg <= ring_rd_data;
        end
        if ((state_reg == pprd_pkg::ST_DIV) && div_rsp.done) begin
            res_rate_reg <= div_rsp.quotient;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_rate_reg    <= res_rate_reg;
            m_event_reg   <= res_event_reg;
            m_extreme_reg <= res_extreme_reg;
            m_falling_reg <= !rising_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_rate          = m_rate_reg;
    assign m_event_res     = m_event_reg;
    assign m_extreme_value = m_extreme_reg;
    assign m_falling_phase = m_falling_reg;

    pprd_ring_mem #(
        .DEPTH   (RING_DEPTH),
        .ADDR_W  (ADDR_W)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data),
        .wr_en   (ring_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (max_pos_reg)
    );

    pprd_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule

// ----- sv/pprd_checker.sv -----
// port-level checks for the pulse peak rate detector, bound to the top level
module pprd_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [pprd_pkg::RATE_W-1:0]        m_rate,
    input logic [1:0]                         m_event_res,
    input logic [pprd_pkg::SAMPLE_W-1:0]      m_extreme_value,
    input logic                               m_falling_phase
);

    // one sample in flight: ready drops after each input transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a sample is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rate) && $stable(m_event_res)
                                && $stable(m_extreme_value) && $stable(m_falling_phase))
        else $error("stalled result changed");

    a_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == pprd_pkg::EV_NONE) |-> (m_rate == '0)
                                                         && (m_extreme_value == '0))
        else $error("result without event carries data");

    a_min_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == pprd_pkg::EV_MIN) |-> (m_rate == '0) && !m_falling_phase)
        else $error("valley result inconsistent");

    a_max_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == pprd_pkg::EV_MAX) |-> m_falling_phase)
        else $error("peak result not in falling phase");

endmodule

bind pulse_peak_rate_detector_core pprd_checker u_pprd_checker (.*);

// ----- dv/pulse_peak_rate_detector_core_tb.sv -----
// self-checking testbench for the pulse peak rate detector core
module pulse_peak_rate_detector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH     = 10;
    localparam int DIRECTED_ROWS  = 21;
    localparam int RANDOM_ITEMS   = 1650;
    // covers the worst item plus sender gap and a long receiver stall
    localparam int WATCHDOG_LIMIT = 4000;
    // the block is done with an item well within this once its transfer is out
    localparam int SETTLE_CYCLES  = 32;
    localparam int TAIL_CYCLES    = 40;
    localparam logic [pprd_pkg::SAMPLE_W-1:0] SAMPLE_TOP = '1;

    typedef struct packed {
        logic [pprd_pkg::RATE_W-1:0]   rate;
        pprd_pkg::event_t              event_res;
        logic [pprd_pkg::SAMPLE_W-1:0] extreme_value;
        logic                          falling_phase;
    } pulse_result_t;

    typedef struct {
        logic [pprd_pkg::SAMPLE_W-1:0] smp;
        bit                            typed;
        pulse_result_t                 want;
    } sample_row_t;

    typedef enum int {
        WAVE_PULSE,
        WAVE_CHATTER,
        WAVE_NOISE
    } wave_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_PATTERN
    } ready_mode_t;

    localparam pulse_result_t QUIET_RISE = '{21'd0, pprd_pkg::EV_NONE, 18'd0, 1'b0};
    localparam pulse_result_t QUIET_FALL = '{21'd0, pprd_pkg::EV_NONE, 18'd0, 1'b1};

    // dut connections, all inputs known from time zero
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    logic [pprd_pkg::SAMPLE_W-1:0]   s_sample  = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    logic [pprd_pkg::RATE_W-1:0]     m_rate;
    logic [1:0]                      m_event_res;
    logic [pprd_pkg::SAMPLE_W-1:0]   m_extreme_value;
    logic                            m_falling_phase;
    logic                            cfg_wr_en = 1'b0;
    logic [pprd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pprd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor copy of the registers and the detector state
    logic [pprd_pkg::HYST_W-1:0]     hyst_cfg;
    logic [pprd_pkg::SPM_W-1:0]      spm_cfg;
    logic                            rising_q;
    logic [pprd_pkg::SAMPLE_W-1:0]   peak_hi;
    logic [pprd_pkg::SAMPLE_W-1:0]   trough_lo;
    logic [pprd_pkg::POS_W-1:0]      sample_no;
    logic [pprd_pkg::POS_W-1:0]      peak_pos;
    logic [pprd_pkg::POS_W-1:0]      peak_ring [RING_DEPTH];
    int                              ring_ptr;
    int                              peaks_seen;

    pulse_result_t         pulse_results_due [$];
    pulse_result_t         due;
    sample_row_t           directed_rows [DIRECTED_ROWS];

    // bookkeeping
    int                    fail_count;
    int                    items_sent;
    int                    results_checked;
    int                    peaks_out;
    int                    troughs_out;
    int                    rates_out;
    int                    zero_spans;
    int                    idle_cycles;
    int                    burst_left;

    // receiver stall pattern
    ready_mode_t           ready_mode;
    int                    ready_left;
    logic [31:0]           ready_word;

    // stimulus shaping for one phase
    wave_t                 wave;
    int                    phase_no;
    int                    phase_len;
    int                    pick;
    int                    amp;
    int                    base;
    int                    half;
    int                    jitter;
    int                    trough;
    int                    pos_in;
    int                    level;
    logic [pprd_pkg::HYST_W-1:0] hyst_next;
    logic [pprd_pkg::SPM_W-1:0]  spm_next;

    pulse_peak_rate_detector_core #(
        .RING_DEPTH (RING_DEPTH)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rate          (m_rate),
        .m_event_res     (m_event_res),
        .m_extreme_value (m_extreme_value),
        .m_falling_phase (m_falling_phase),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // one sample through the detector: hysteresis tracking of maxima and
    // minima, ring of peak positions and the beats-per-minute division
    function automatic pulse_result_t track_pulse(
        input logic [pprd_pkg::SAMPLE_W-1:0] smp);
        pulse_result_t              res;
        logic [pprd_pkg::POS_W-1:0] old_pos;
        logic [pprd_pkg::POS_W-1:0] span;
        logic [pprd_pkg::POS_W-1:0] numer;
        bit                         rated;
        res = '0;
        rated = 1'b0;
        numer = '0;
        span = '0;
        sample_no = sample_no + 1'b1;
        if (rising_q) begin
            if (smp > peak_hi) begin
                peak_hi = smp;
                peak_pos = sample_no;
            end else if ((peak_hi - smp) > hyst_cfg) begin
                // maximum confirmed: swap the ring slot for this peak's position
                old_pos = peak_ring[ring_ptr];
                peak_ring[ring_ptr] = peak_pos;
                ring_ptr = (ring_ptr + 1) % RING_DEPTH;
                rising_q = 1'b0;
                trough_lo = peak_hi;
                res.event_res = pprd_pkg::EV_MAX;
                res.extreme_value = peak_hi;
                if (peaks_seen < RING_DEPTH + 2)
                    peaks_seen++;
                if (peaks_seen == pprd_pkg::QUICK_COUNT) begin
                    // quick estimate over three intervals back to the second peak
                    rated = 1'b1;
                    numer = pprd_pkg::QUICK_SPANS * spm_cfg;
                    span = peak_pos - peak_ring[pprd_pkg::QUICK_ENTRY];
                end else if (peaks_seen >= RING_DEPTH + 2) begin
                    // full ring: span back to the peak just overwritten
                    rated = 1'b1;
                    numer = RING_DEPTH * spm_cfg;
                    span = peak_pos - old_pos;
                end
                if (rated) begin
                    if (span == '0)
                        zero_spans++;
                    else
                        res.rate = pprd_pkg::RATE_W'(numer / span);
                end
            end
        end else begin
            if (smp < trough_lo) begin
                trough_lo = smp;
            end else if ((smp - trough_lo) > hyst_cfg) begin
                // minimum confirmed, maximum tracking restarts from the trough
                rising_q = 1'b1;
                peak_hi = trough_lo;
                res.event_res = pprd_pkg::EV_MIN;
                res.extreme_value = trough_lo;
            end
        end
        res.falling_phase = ~rising_q;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
                 $realtime, results_checked, what, got, want);
        fail_count++;
    endtask

    // register write, only once every outstanding result has been taken
    task automatic write_register(input pprd_pkg::cfg_reg_t idx,
                                  input logic [pprd_pkg::CFG_DATA_W-1:0] val);
        while (pulse_results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            pprd_pkg::REG_HYSTERESIS: hyst_cfg = val[pprd_pkg::HYST_W-1:0];
            pprd_pkg::REG_SPM:        spm_cfg = val[pprd_pkg::SPM_W-1:0];
            default:                  ;
        endcase
    endtask

    // offer one sample and hold it until the transfer; valid stays high into the next call
    // while a burst lasts and the sample is not the last, otherwise it drops, with a gap when the burst ends
    task automatic send_sample(input logic [pprd_pkg::SAMPLE_W-1:0] smp, input bit typed,
                               input pulse_result_t want, input bit last);
        pulse_result_t predicted;
        int            gap;
        s_valid  <= 1'b1;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = track_pulse(smp);
        pulse_results_due.push_back(typed ? want : predicted);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (last || burst_left == 0)
            s_valid <= 1'b0;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge aclk);
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // receiver: a mode of its own, redrawn whenever its run count expires
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (ready_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                ready_left = $urandom_range(32, 300);
                ready_word = $urandom | 32'd1;
            end else begin
                ready_left--;
                ready_word = {ready_word[0], ready_word[31:1]};
            end
            case (ready_mode)
                RDY_ALWAYS:  m_ready <= 1'b1;
                RDY_COIN:    m_ready <= 1'($urandom_range(0, 1));
                RDY_MOSTLY:  m_ready <= ($urandom_range(0, 4) != 0);
                default:     m_ready <= ready_word[0];
            endcase
        end
    end

    // result checker: each result transfer against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pulse_results_due.size() == 0) begin
                report_mismatch("unpredicted result, rate", m_rate, 0);
            end else begin
                due = pulse_results_due.pop_front();
                if (m_rate !== due.rate)
                    report_mismatch("rate", m_rate, due.rate);
                if (m_event_res !== due.event_res)
                    report_mismatch("event", m_event_res, due.event_res);
                if (m_extreme_value !== due.extreme_value)
                    report_mismatch("extreme value", m_extreme_value, due.extreme_value);
                if (m_falling_phase !== due.falling_phase)
                    report_mismatch("falling phase", m_falling_phase, due.falling_phase);
                if (due.event_res == pprd_pkg::EV_MAX)
                    peaks_out++;
                if (due.event_res == pprd_pkg::EV_MIN)
                    troughs_out++;
                if (due.rate != '0)
                    rates_out++;
            end
            results_checked++;
        end
    end

    // watchdog on cycles with neither transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $realtime, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        // predictor state after reset
        hyst_cfg   = pprd_pkg::HYST_RESET;
        spm_cfg    = pprd_pkg::SPM_RESET;
        rising_q   = 1'b1;
        peak_hi    = '0;
        trough_lo  = SAMPLE_TOP;
        sample_no  = '0;
        peak_pos   = '0;
        for (int i = 0; i < RING_DEPTH; i++)
            peak_ring[i] = '0;
        ring_ptr   = 0;
        peaks_seen = 0;
        fail_count = 0;
        items_sent = 0;
        results_checked = 0;
        peaks_out  = 0;
        troughs_out = 0;
        rates_out  = 0;
        zero_spans = 0;
        idle_cycles = 0;
        burst_left = 8;
        ready_mode = RDY_ALWAYS;
        ready_left = 0;
        ready_word = 32'd1;

        // directed run on the reset settings: full-scale swing, the exact
        // hysteresis boundary, a trough at zero, then four more peaks so the
        // fifth gives the quick three-interval rate
        directed_rows = '{
            '{18'd0,      1'b1, QUIET_RISE},
            '{SAMPLE_TOP, 1'b1, QUIET_RISE},
            '{18'd261843, 1'b1, QUIET_RISE},
            '{18'd261842, 1'b1, '{21'd0, pprd_pkg::EV_MAX, SAMPLE_TOP, 1'b1}},
            '{18'd0,      1'b1, QUIET_FALL},
            '{18'd300,    1'b1, QUIET_FALL},
            '{18'd301,    1'b1, '{21'd0, pprd_pkg::EV_MIN, 18'd0, 1'b0}},
            '{18'd1000,   1'b0, QUIET_RISE},
            '{18'd600,    1'b0, QUIET_RISE},
            '{18'd100,    1'b0, QUIET_RISE},
            '{18'd500,    1'b0, QUIET_RISE},
            '{18'd1000,   1'b0, QUIET_RISE},
            '{18'd600,    1'b0, QUIET_RISE},
            '{18'd100,    1'b0, QUIET_RISE},
            '{18'd500,    1'b0, QUIET_RISE},
            '{18'd1000,   1'b0, QUIET_RISE},
            '{18'd600,    1'b0, QUIET_RISE},
            '{18'd100,    1'b0, QUIET_RISE},
            '{18'd500,    1'b0, QUIET_RISE},
            '{18'd1000,   1'b0, QUIET_RISE},
            '{18'd600,    1'b0, QUIET_RISE}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_sample(directed_rows[r].smp, directed_rows[r].typed,
                        directed_rows[r].want, r == DIRECTED_ROWS - 1);

        // random phases, each with its own register settings and waveform;
        // the first few pin the register extremes
        phase_no = 0;
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            case (phase_no)
                0: begin
                    wave = WAVE_CHATTER;
                    spm_next = '1;
                end
                1: begin
                    wave = WAVE_NOISE;
                    spm_next = 16'd1;
                end
                2: begin
                    wave = WAVE_PULSE;
                    spm_next = 16'd1;
                end
                3: begin
                    wave = WAVE_NOISE;
                    spm_next = '1;
                end
                default: begin
                    pick = $urandom_range(0, 9);
                    wave = (pick < 6) ? WAVE_PULSE : (pick < 8) ? WAVE_CHATTER : WAVE_NOISE;
                    pick = $urandom_range(0, 7);
                    spm_next = (pick == 0) ? 16'd1 : (pick == 1) ? '1
                               : pprd_pkg::SPM_W'($urandom_range(1, 65535));
                end
            endcase

            // waveform shape and a hysteresis that suits it
            amp    = $urandom_range(16, 60000);
            base   = $urandom_range(0, 262143 - amp);
            half   = $urandom_range(2, 40);
            jitter = $urandom_range(0, amp / 8);
            case (wave)
                WAVE_PULSE:   hyst_next = pprd_pkg::HYST_W'($urandom_range(0, amp / 3));
                WAVE_CHATTER: hyst_next = pprd_pkg::HYST_W'($urandom_range(0, 2000));
                default:      hyst_next = pprd_pkg::HYST_W'($urandom_range(0, 262143));
            endcase
            if (phase_no == 0 || phase_no == 2 || phase_no == 3)
                hyst_next = '0;
            if (phase_no == 1)
                hyst_next = '1;
            trough = $urandom_range(hyst_next + 1, 262141 - 2 * hyst_next);

            write_register(pprd_pkg::REG_HYSTERESIS, pprd_pkg::CFG_DATA_W'(hyst_next));
            write_register(pprd_pkg::REG_SPM, pprd_pkg::CFG_DATA_W'(spm_next));

            phase_len = $urandom_range(40, 160);
            for (int k = 0; k < phase_len; k++) begin
                case (wave)
                    WAVE_PULSE: begin
                        // noisy triangle, clipped at both rails
                        pos_in = k % (2 * half);
                        level = (pos_in < half) ? amp * pos_in / half
                                                : amp * (2 * half - pos_in) / half;
                        level = base + level + $urandom_range(0, jitter) - jitter / 2;
                        if (level < 0)
                            level = 0;
                        if (level > 262143)
                            level = 262143;
                    end
                    WAVE_CHATTER: begin
                        // settle into falling with the trough as minimum, then
                        // alternate just past the hysteresis either side so
                        // every maximum reuses one stale position (zero span)
                        if (k < 2)
                            level = trough + 2 * hyst_next + 2;
                        else if (k < 4)
                            level = trough;
                        else if (k % 2 == 0)
                            level = trough + hyst_next + 1;
                        else
                            level = trough - hyst_next - 1;
                    end
                    default: level = $urandom_range(0, 262143);
                endcase
                send_sample(pprd_pkg::SAMPLE_W'(level), 1'b0, QUIET_RISE,
                            k == phase_len - 1);
            end
            phase_no++;
        end

        // drain, then let the block sit to catch any stray result
        while (pulse_results_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d samples over %0d register settings", items_sent,
                 phase_no + 1);
        $display("%0d results checked: %0d peaks, %0d troughs, %0d rates, %0d zero spans",
                 results_checked, peaks_out, troughs_out, rates_out, zero_spans);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
